[sv/masked_median_gain_estimator_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the masked median gain estimator
// ---------------------------------------------------------------------------
`ifndef MASKED_MEDIAN_GAIN_ESTIMATOR_TOP_DEFINES_SVH
`define MASKED_MEDIAN_GAIN_ESTIMATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MMG_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) else $error(msg);

// next-cycle implication, disabled during reset
`define MMG_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) else $error(msg);

`endif

[sv/mmg_pkg.sv]
// ---------------------------------------------------------------------------
// mmg_pkg
// Types, constants and codes shared by the masked median gain estimator.
// ---------------------------------------------------------------------------
package mmg_pkg;

  localparam int NUM_CH    = 3;
  localparam int NUM_BINS  = 256;
  localparam int BIN_W     = 8;
  localparam int CH_W      = 2;
  localparam int DEPTH     = NUM_CH * NUM_BINS;
  localparam int ADDR_W    = CH_W + BIN_W;
  localparam int CNT_W     = 20;
  localparam int RUN_W     = CNT_W + BIN_W;
  localparam int GAIN_W    = 12;
  localparam int QUO_W     = 2 * BIN_W;
  localparam int DIV_CNT_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(NUM_CH - 1);
  localparam logic [GAIN_W-1:0] GAIN_LOW_RST  = 12'd154;
  localparam logic [GAIN_W-1:0] GAIN_HIGH_RST = 12'd435;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HIGH = 2'd1;

  // channel codes
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_RED   = 2'd2;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_UPD,
    ST_WB,
    ST_SCAN,
    ST_SDRAIN,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [7:0] frame_blue;
    logic [7:0] frame_green;
    logic [7:0] frame_red;
    logic [7:0] back_blue;
    logic [7:0] back_green;
    logic [7:0] back_red;
    logic       in_sample;
    logic       last_pixel;
  } in_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_blue;
    logic [GAIN_W-1:0] gain_green;
    logic [GAIN_W-1:0] gain_red;
    logic              illumination_valid;
    logic [7:0]        frame_median_green;
    logic [7:0]        back_median_green;
  } out_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

[sv/mmg_ram.sv]
// ---------------------------------------------------------------------------
// mmg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module mmg_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/mmg_div.sv]
// ---------------------------------------------------------------------------
// mmg_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mmg_div
  import mmg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl_in,
  output div_ctl_t         ctl_out,
  input  logic [QUO_W-1:0] dividend,
  input  logic [BIN_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [BIN_W-1:0]     rem_r;
  logic [BIN_W-1:0]     dvs_r;
  logic [QUO_W-1:0]     dvd_r;
  logic [BIN_W:0]       trial;
  logic                 qbit;

  // one trial subtraction per cycle
  assign trial = {rem_r, dvd_r[QUO_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (ctl_in.start && !busy_r) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= qbit ? BIN_W'(trial - {1'b0, dvs_r}) : trial[BIN_W-1:0];
      dvd_r <= {dvd_r[QUO_W-2:0], qbit};
    end
  end

  assign ctl_out.start = 1'b0;
  assign ctl_out.done  = done_r;
  assign quotient      = dvd_r;

endmodule

[sv/masked_median_gain_estimator_top.sv]
// ---------------------------------------------------------------------------
// masked_median_gain_estimator_top
// Masked per-channel histograms, median search and clamped Q4.8 gains.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : pixel transfers (frame and background pixel, mask bit, last flag).
//   out_* : one result transfer per frame, after the pixel with last_pixel.
//   cfg_* : gain limit writes, always ready; write only while idle.
// Pixel input: a masked pixel stalls the input during three read-modify-write
// passes over the two histogram RAMs, one channel per cycle; the next pixel
// can be taken during write-back. An unmasked pixel does not stall the input.
// After the last pixel: a scan of both RAMs that finds the medians and clears
// every bin, then three serial divisions (start, 16 steps, done), before the
// result is registered.
// Reset: a clearing pass zeroes both RAMs; no pixel is taken meanwhile.
// Limits return to 154 and 435.
// Stall: the result waits in an output register; pixels of the next frame
// are still taken, and a frame end waits only if that register is full.
// ---------------------------------------------------------------------------
`include "masked_median_gain_estimator_top_defines.svh"

module masked_median_gain_estimator_top
  import mmg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  state_t            state_r, state_nxt;
  logic [CH_W-1:0]   ch_r;
  in_t               pix_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [GAIN_W-1:0] lo_r, hi_r;
  logic              upd_pend_r, scan_pend_r;
  logic [ADDR_W-1:0] fq_addr_r, bq_addr_r, scan_addr_r;
  logic [RUN_W-1:0]  fr_run_r, bk_run_r;
  logic              fr_found_r, bk_found_r;
  logic [BIN_W-1:0]  fmed_r [NUM_CH];
  logic [BIN_W-1:0]  bmed_r [NUM_CH];
  logic [GAIN_W-1:0] gain_r [NUM_CH];
  logic              ok_r;
  logic [CH_W-1:0]   div_ch_r;
  logic              out_valid_r;
  out_t              out_r;

  logic              in_acc;
  logic              out_load;
  logic              we;
  logic [ADDR_W-1:0] waddr, f_raddr, b_raddr;
  logic [CNT_W-1:0]  f_rdata, b_rdata, f_wdata, b_wdata;
  logic [BIN_W-1:0]  fv, bv;
  logic [BIN_W-1:0]  sbin;
  logic [CH_W-1:0]   sch;
  logic [RUN_W-1:0]  fr_run_nxt, bk_run_nxt;
  logic              fr_hit, bk_hit;
  logic [BIN_W-1:0]  div_fmed;
  div_ctl_t          div_in, div_out;
  logic [QUO_W-1:0]  quo;
  logic              gain_bad;
  logic [QUO_W-1:0]  clamp_hi;
  logic [QUO_W-1:0]  clamped;
  logic [BIN_W-1:0]  fmed_green;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == ST_FIN) && !(out_valid_r && out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:    if (scan_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE, ST_WB: begin
        if (state_r == ST_WB) begin
          state_nxt = pix_r.last_pixel ? ST_SCAN : ST_IDLE;
        end
        if (in_acc) begin
          if (in_data.in_sample)       state_nxt = ST_UPD;
          else if (in_data.last_pixel) state_nxt = ST_SCAN;
          else                         state_nxt = ST_IDLE;
        end
      end
      ST_UPD:    if (ch_r == LAST_CH) state_nxt = ST_WB;
      ST_SCAN:   if (scan_addr_r == LAST_ADDR) state_nxt = ST_SDRAIN;
      ST_SDRAIN: state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_out.done) state_nxt = (div_ch_r == LAST_CH) ? ST_FIN : ST_DSTART;
      end
      ST_FIN:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLR;
    endcase
  end

  // handshake and RAM control
  always_comb begin
    in_stall = !((state_r == ST_IDLE) || ((state_r == ST_WB) && !pix_r.last_pixel));
    case (ch_r)
      CH_BLUE:  begin fv = pix_r.frame_blue;  bv = pix_r.back_blue;  end
      CH_GREEN: begin fv = pix_r.frame_green; bv = pix_r.back_green; end
      CH_RED:   begin fv = pix_r.frame_red;   bv = pix_r.back_red;   end
      default:  begin fv = '0;                bv = '0;               end
    endcase
    if (state_r == ST_UPD) begin
      f_raddr = {ch_r, fv};
      b_raddr = {ch_r, bv};
    end else begin
      f_raddr = scan_addr_r;
      b_raddr = scan_addr_r;
    end
    we    = upd_pend_r || scan_pend_r || (state_r == ST_CLR);
    waddr = (state_r == ST_CLR) ? scan_addr_r : fq_addr_r;
    // saturating increment on update, zero on scan and clear
    f_wdata = '0;
    b_wdata = '0;
    if (upd_pend_r) begin
      f_wdata = (f_rdata == CNT_MAX) ? f_rdata : f_rdata + 1'b1;
      b_wdata = (b_rdata == CNT_MAX) ? b_rdata : b_rdata + 1'b1;
    end
  end

  // both RAMs share the write timing; background uses its own address
  mmg_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  mmg_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_back_ram (
    .clk   (clk),
    .we    (we),
    .waddr ((state_r == ST_CLR) ? scan_addr_r : bq_addr_r),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // median scan: running sums restart at bin zero of each channel
  always_comb begin
    sbin       = fq_addr_r[BIN_W-1:0];
    sch        = fq_addr_r[ADDR_W-1:BIN_W];
    fr_run_nxt = ((sbin == '0) ? '0 : fr_run_r) + RUN_W'(f_rdata);
    bk_run_nxt = ((sbin == '0) ? '0 : bk_run_r) + RUN_W'(b_rdata);
    fr_hit     = !((sbin != '0) && fr_found_r) &&
                 ({fr_run_nxt, 1'b0} >= (RUN_W + 1)'(cnt_r));
    bk_hit     = !((sbin != '0) && bk_found_r) &&
                 ({bk_run_nxt, 1'b0} >= (RUN_W + 1)'(cnt_r));
  end

  // divider operands, gain check and clamp
  always_comb begin
    div_fmed     = (fmed_r[div_ch_r] == '0) ? BIN_W'(1) : fmed_r[div_ch_r];
    div_in.start = (state_r == ST_DSTART);
    div_in.done  = 1'b0;
    gain_bad     = (quo < QUO_W'(lo_r)) || (quo > QUO_W'(hi_r));
    clamp_hi     = (quo < QUO_W'(hi_r)) ? quo : QUO_W'(hi_r);
    clamped      = (clamp_hi < QUO_W'(lo_r)) ? QUO_W'(lo_r) : clamp_hi;
    fmed_green   = (fmed_r[CH_GREEN] == '0) ? BIN_W'(1) : fmed_r[CH_GREEN];
  end

  mmg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (div_in),
    .ctl_out  (div_out),
    .dividend ({bmed_r[div_ch_r], BIN_W'(0)}),
    .divisor  (div_fmed),
    .quotient (quo)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ch_r        <= '0;
      cnt_r       <= '0;
      lo_r        <= GAIN_LOW_RST;
      hi_r        <= GAIN_HIGH_RST;
      upd_pend_r  <= 1'b0;
      scan_pend_r <= 1'b0;
      scan_addr_r <= '0;
      div_ch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      upd_pend_r  <= (state_r == ST_UPD);
      scan_pend_r <= (state_r == ST_SCAN);
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GAIN_LOW)  lo_r <= cfg_data;
        if (cfg_index == CFG_GAIN_HIGH) hi_r <= cfg_data;
      end
      // channel sequencing of a pixel update
      if (in_acc)                  ch_r <= '0;
      else if (state_r == ST_UPD)  ch_r <= ch_r + 1'b1;
      // masked pixel count, cleared once the scan is done
      if (in_acc && in_data.in_sample && (cnt_r != CNT_MAX)) cnt_r <= cnt_r + 1'b1;
      else if (state_r == ST_SDRAIN)                         cnt_r <= '0;
      // sweep address for clear and scan
      if ((state_r == ST_CLR) || (state_r == ST_SCAN)) begin
        scan_addr_r <= (scan_addr_r == LAST_ADDR) ? '0 : scan_addr_r + 1'b1;
      end
      // divider channel
      if (state_r == ST_SDRAIN)               div_ch_r <= '0;
      else if ((state_r == ST_DWAIT) && div_out.done) div_ch_r <= div_ch_r + 1'b1;
      // result register
      if (out_load)                         out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)   out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) pix_r <= in_data;
    fq_addr_r <= f_raddr;
    bq_addr_r <= b_raddr;
    if (scan_pend_r) begin
      fr_run_r <= fr_run_nxt;
      bk_run_r <= bk_run_nxt;
      if (sbin == '0) begin
        fr_found_r  <= fr_hit;
        bk_found_r  <= bk_hit;
        fmed_r[sch] <= '0;
        bmed_r[sch] <= '0;
      end else begin
        if (fr_hit) begin
          fr_found_r  <= 1'b1;
          fmed_r[sch] <= sbin;
        end
        if (bk_hit) begin
          bk_found_r  <= 1'b1;
          bmed_r[sch] <= sbin;
        end
      end
    end
    if (state_r == ST_SDRAIN) ok_r <= 1'b1;
    if ((state_r == ST_DWAIT) && div_out.done) begin
      gain_r[div_ch_r] <= clamped[GAIN_W-1:0];
      if (gain_bad) ok_r <= 1'b0;
    end
    if (out_load) begin
      out_r.gain_blue          <= gain_r[CH_BLUE];
      out_r.gain_green         <= gain_r[CH_GREEN];
      out_r.gain_red           <= gain_r[CH_RED];
      out_r.illumination_valid <= ok_r;
      out_r.frame_median_green <= fmed_green;
      out_r.back_median_green  <= bmed_r[CH_GREEN];
    end
  end

  // checks
  `MMG_ASSERT_NOW(a_no_pix_in_scan, (state_r == ST_SCAN) || (state_r == ST_CLR), in_stall, "pixel taken during scan or clear")
  `MMG_ASSERT_NOW(a_no_wr_overlap, upd_pend_r, !scan_pend_r, "update write overlaps scan write")
  `MMG_ASSERT_NOW(a_upd_masked, state_r == ST_UPD, pix_r.in_sample, "histogram update for unmasked pixel")
  `MMG_ASSERT_NEXT(a_res_once, out_load, out_valid_r && (state_r == ST_IDLE), "result not registered")

endmodule

[verif/mmg_checker.sv]
// ---------------------------------------------------------------------------
// mmg_checker
// Watches pixel, result and limit-write transfers, keeps its own masked
// histograms and limits, predicts each frame result and compares it field by
// field with the result transfers of the block.
// ---------------------------------------------------------------------------
module mmg_checker
  import mmg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic [CNT_W-1:0]  frame_hist [DEPTH];
  logic [CNT_W-1:0]  back_hist  [DEPTH];
  logic [CNT_W-1:0]  mask_total;
  logic [GAIN_W-1:0] low_lim;
  logic [GAIN_W-1:0] high_lim;
  out_t              gain_q [$];

  assign pending = gain_q.size();

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // first bin whose running count doubled reaches the mask total
  function automatic logic [7:0] median_bin(bit use_frame, int ch);
    longint running;
    running = 0;
    for (int b = 0; b < NUM_BINS; b++) begin
      running += use_frame ? frame_hist[ch*NUM_BINS+b] : back_hist[ch*NUM_BINS+b];
      if (2 * running >= longint'(mask_total)) return b[7:0];
    end
    return 8'd0;
  endfunction

  function automatic out_t frame_gains();
    out_t r;
    logic [7:0] fm, bm;
    logic [15:0] g;
    logic [15:0] cl;
    logic [GAIN_W-1:0] gv [3];
    r = '0;
    r.illumination_valid = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      fm = median_bin(1, c);
      bm = median_bin(0, c);
      if (fm == 0) fm = 8'd1;
      g = {bm, 8'd0} / fm;
      if (g < low_lim || g > high_lim) r.illumination_valid = 1'b0;
      cl = (g < high_lim) ? g : 16'(high_lim);
      if (cl < low_lim) cl = 16'(low_lim);
      gv[c] = cl[GAIN_W-1:0];
      if (c == CH_GREEN) begin
        r.frame_median_green = fm;
        r.back_median_green  = bm;
      end
    end
    r.gain_blue  = gv[CH_BLUE];
    r.gain_green = gv[CH_GREEN];
    r.gain_red   = gv[CH_RED];
    return r;
  endfunction

  function automatic void clear_hist();
    for (int i = 0; i < DEPTH; i++) begin
      frame_hist[i] = '0;
      back_hist[i]  = '0;
    end
    mask_total = '0;
  endfunction

  always @(posedge clk) begin
    out_t ex;
    logic [7:0] fv [3];
    logic [7:0] bv [3];
    if (!rst_n) begin
      clear_hist();
      low_lim    = GAIN_LOW_RST;
      high_lim   = GAIN_HIGH_RST;
      fail_count = 0;
      gain_q.delete();
    end else begin
      // limit write
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GAIN_LOW) low_lim = cfg_data;
        else if (cfg_index == CFG_GAIN_HIGH) high_lim = cfg_data;
      end
      // result transfer
      if (out_valid && !out_stall) begin
        if (gain_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          ex = gain_q.pop_front();
          if (out_data.gain_blue !== ex.gain_blue) begin
            $error("gain_blue exp %0d got %0d", ex.gain_blue, out_data.gain_blue);
            fail_count++;
          end
          if (out_data.gain_green !== ex.gain_green) begin
            $error("gain_green exp %0d got %0d", ex.gain_green, out_data.gain_green);
            fail_count++;
          end
          if (out_data.gain_red !== ex.gain_red) begin
            $error("gain_red exp %0d got %0d", ex.gain_red, out_data.gain_red);
            fail_count++;
          end
          if (out_data.illumination_valid !== ex.illumination_valid) begin
            $error("illumination_valid exp %0d got %0d", ex.illumination_valid,
                   out_data.illumination_valid);
            fail_count++;
          end
          if (out_data.frame_median_green !== ex.frame_median_green) begin
            $error("frame_median_green exp %0d got %0d", ex.frame_median_green,
                   out_data.frame_median_green);
            fail_count++;
          end
          if (out_data.back_median_green !== ex.back_median_green) begin
            $error("back_median_green exp %0d got %0d", ex.back_median_green,
                   out_data.back_median_green);
            fail_count++;
          end
        end
      end
      // pixel transfer
      if (in_valid && !in_stall) begin
        fv = '{in_data.frame_blue, in_data.frame_green, in_data.frame_red};
        bv = '{in_data.back_blue, in_data.back_green, in_data.back_red};
        if (in_data.in_sample) begin
          for (int c = 0; c < NUM_CH; c++) begin
            frame_hist[c*NUM_BINS+fv[c]] = sat_inc(frame_hist[c*NUM_BINS+fv[c]]);
            back_hist[c*NUM_BINS+bv[c]]  = sat_inc(back_hist[c*NUM_BINS+bv[c]]);
          end
          mask_total = sat_inc(mask_total);
        end
        if (in_data.last_pixel) begin
          gain_q.insert(gain_q.size(), frame_gains());
          clear_hist();
        end
      end
    end
  end

endmodule

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Drives pixel frames and gain-limit writes into the estimator with random
// gaps and result back-pressure; the checker predicts and compares results.
// ---------------------------------------------------------------------------
module tb_top
  import mmg_pkg::*;
;

  localparam int N_RANDOM  = 780;
  localparam int CYC_LIMIT = 3000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;
  int                   cycles;
  bit                   rx_free;

  masked_median_gain_estimator_top dut (.*);

  mmg_checker chk (.*);

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("masked_median_gain_estimator_top verification failed");
      $finish;
    end
  end

  // receiver back-pressure: random stall length per result transfer
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!rx_free && ($urandom_range(0, 3) == 0)) hold = $urandom_range(0, 16);
      else                                          hold = 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      if (out_valid) @(posedge clk);
    end
  end

  // one pixel transfer after a random gap; returns at the accepting edge
  task automatic send_pixel(in_t px, bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop pixel input, drain all results, then keep the input idle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
  endtask

  function automatic in_t rand_pixel(bit last, int sample_pct);
    in_t p;
    p = in_t'({$urandom, $urandom});
    p.in_sample  = ($urandom_range(0, 99) < sample_pct);
    p.last_pixel = last;
    return p;
  endfunction

  // random frame: green and blue values of most pixels clustered near a per-frame center for sane gains
  task automatic send_frame(int len);
    in_t p;
    int fc, bc;
    fc = $urandom_range(0, 255);
    bc = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      p = rand_pixel(i == len - 1, 80);
      if ($urandom_range(0, 3) != 0) begin
        p.frame_green = 8'((fc + $urandom_range(0, 20)) % 256);
        p.back_green  = 8'((bc + $urandom_range(0, 20)) % 256);
        p.frame_blue  = 8'((fc + $urandom_range(0, 30)) % 256);
        p.back_blue   = 8'((bc + $urandom_range(0, 30)) % 256);
      end
      send_pixel(p, 1'b0);
    end
  endtask

  initial begin
    in_t p;
    int sent;
    cycles    = 0;
    rx_free   = 1'b1;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GAIN_LOW;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty mask frame, default limits
    send_pixel(in_t'('0) | in_t'(1), 1'b1);
    // extremes: all zero and all ones in one frame
    p = '0; p.in_sample = 1'b1;
    send_pixel(p, 1'b1);
    p = '1; p.last_pixel = 1'b0;
    send_pixel(p, 1'b1);
    p = '1;
    send_pixel(p, 1'b1);
    // dark frame against bright background: very high gain
    p = '0; p.in_sample = 1'b1;
    p.back_blue = 8'hff; p.back_green = 8'hff; p.back_red = 8'hff;
    p.last_pixel = 1'b1;
    send_pixel(p, 1'b1);
    // equal frame and background: unit gain
    p = '{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 1'b1, 1'b1};
    send_pixel(p, 1'b1);
    // single-pixel frame with mask bit off
    p = rand_pixel(1'b1, 0);
    send_pixel(p, 1'b1);
    wait_idle();

    // crossed limits
    write_limit(CFG_GAIN_LOW, 12'd900);
    write_limit(CFG_GAIN_HIGH, 12'd100);
    send_frame(6);
    wait_idle();
    // widest limits
    write_limit(CFG_GAIN_LOW, 12'd0);
    write_limit(CFG_GAIN_HIGH, 12'hfff);
    send_frame(5);
    send_frame(3);
    wait_idle();
    // index beyond the list is ignored
    write_limit(2'd3, 12'd7);
    write_limit(2'd2, 12'd7);
    send_frame(4);
    wait_idle();
    // narrowest limits at both ends
    write_limit(CFG_GAIN_LOW, 12'hfff);
    write_limit(CFG_GAIN_HIGH, 12'hfff);
    send_frame(3);
    wait_idle();
    write_limit(CFG_GAIN_LOW, 12'd0);
    write_limit(CFG_GAIN_HIGH, 12'd0);
    send_frame(3);
    wait_idle();

    // random phases, with back-pressure active
    rx_free = 1'b0;
    sent = 0;
    for (int ph = 0; sent < N_RANDOM; ph++) begin
      if (ph % 3 == 0) begin
        write_limit(CFG_GAIN_LOW, 12'($urandom_range(0, 400)));
        write_limit(CFG_GAIN_HIGH, 12'($urandom_range(200, 4095)));
      end
      for (int f = 0; f < 4; f++) begin
        int len;
        len = $urandom_range(1, 24);
        if ($urandom_range(0, 5) == 0) begin
          // noise frame: fully random pixels
          for (int i = 0; i < len; i++) send_pixel(rand_pixel(i == len - 1, 50), 1'b0);
        end else begin
          send_frame(len);
        end
        sent += len;
      end
      wait_idle();
    end
    // default limits again
    write_limit(CFG_GAIN_LOW, GAIN_LOW_RST);
    write_limit(CFG_GAIN_HIGH, GAIN_HIGH_RST);
    send_frame(10);
    wait_idle();

    if (fail_count == 0) begin
      $display("masked_median_gain_estimator_top verification clean");
    end else begin
      $display("masked_median_gain_estimator_top verification failed");
    end
    $finish;
  end

endmodule
